// ===== src/chained_hash_set_assert.svh =====
// ----------------------------------------------------------------------------
// chained_hash_set_assert.svh
// Assertion macros used by the hash set checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_ASSERT_SVH
`define CHAINED_HASH_SET_ASSERT_SVH

// same-cycle implication
`define CHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Widths, defaults and operation codes of the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

   localparam int KEY_W           = 31;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 8;
   localparam int BUCKETS_DEF     = 16;
   localparam int CHAIN_DEPTH_DEF = 8;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

endpackage

// ===== src/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/chained_hash_set.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set of 31-bit keys with separate chaining in fixed-depth chains.
//
//   channel  dir  word
//   req      in   tdata = key (bits 30:0), tuser = func (0 insert, 1 search)
//   rsp      out  tdata = found (bit 0), status (bit 1)
//
// After reset the chain counts are cleared, one bucket a cycle, with req_tready low.
// The bucket index takes a reciprocal multiply for the quotient (ST_MOD), then
// the remainder (ST_LEN_RD). Insert passes ST_MOD, ST_LEN_RD, ST_LEN, ST_DONE
// from accept to rsp_tvalid; the next accept waits for ST_IDLE. Search adds one
// key RAM read and one compare per stored entry compared, stopping at the first match.
// A held result does not block the next accept; the next result waits for it.
// ----------------------------------------------------------------------------
module chained_hash_set #(
   parameter int BUCKETS     = chs_pkg::BUCKETS_DEF,
   parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [chs_pkg::REQ_DATA_W-1:0] req_tdata,  // key, zero pad
   input  logic                          req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [chs_pkg::RSP_DATA_W-1:0] rsp_tdata   // found, status, zero pad
);

   import chs_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   localparam int CW = $clog2(CHAIN_DEPTH + 1);
   localparam int KA = $clog2(BUCKETS * CHAIN_DEPTH);
   localparam int QS = KEY_W + BW;

   localparam logic [63:0]     RECIP_L  = ((64'd1 << QS) + 64'(BUCKETS) - 64'd1) /
                                          64'(BUCKETS);
   localparam logic [KEY_W:0]  RECIP    = RECIP_L[KEY_W:0];
   localparam logic [BW-1:0]   BKT_LO   = BW'(BUCKETS);
   localparam logic [BW-1:0]   LAST_BKT = BW'(BUCKETS - 1);
   localparam logic [CW-1:0]   DEPTH_C  = CW'(CHAIN_DEPTH);
   localparam logic [KA-1:0]   DEPTH_K  = KA'(CHAIN_DEPTH);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_MOD     = 3'd2;
   localparam logic [2:0] ST_LEN_RD  = 3'd3;
   localparam logic [2:0] ST_LEN     = 3'd4;
   localparam logic [2:0] ST_KEY_RD  = 3'd5;
   localparam logic [2:0] ST_KEY_CMP = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             func_ff, func_in;
   logic [BW-1:0]    quot_ff, quot_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             found_ff, found_in;
   logic             status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic             rsp_status_ff, rsp_status_in;

   logic [2*KEY_W:0] prod;
   logic [BW-1:0]    bucket_rem;
   logic [KA-1:0]    base;
   logic [CW-1:0]    len_rdata;
   logic [KEY_W-1:0] key_rdata;
   logic             room;
   logic             do_insert;
   logic             len_wr_en;
   logic [BW-1:0]    len_wr_addr;
   logic [CW-1:0]    len_wr_data;
   logic [KA-1:0]    key_wr_addr;
   logic [KA-1:0]    key_rd_addr;
   logic [CW-1:0]    idx_inc;

   // reciprocal multiply for the bucket quotient
   assign prod       = {{(KEY_W + 1){1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
   assign bucket_rem = key_ff[BW-1:0] - quot_ff * BKT_LO;

   assign base        = KA'(bucket_ff) * DEPTH_K;
   assign room        = len_rdata < DEPTH_C;
   assign do_insert   = (state_ff == ST_LEN) && (func_ff == FUNC_INSERT) && room;
   assign len_wr_en   = (state_ff == ST_CLEAR) || do_insert;
   assign len_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : bucket_ff;
   assign len_wr_data = (state_ff == ST_CLEAR) ? '0 : len_rdata + CW'(1);
   assign key_wr_addr = base + KA'(len_rdata);
   assign key_rd_addr = base + KA'(idx_ff);
   assign idx_inc     = idx_ff + CW'(1);

   chs_ram #(
      .WIDTH (CW),
      .DEPTH (BUCKETS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_addr (bucket_rem),
      .rd_data (len_rdata)
   );

   chs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (BUCKETS * CHAIN_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (do_insert),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_addr (key_rd_addr),
      .rd_data (key_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      func_in       = func_ff;
      quot_in       = quot_ff;
      bucket_in     = bucket_ff;
      clr_in        = clr_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + BW'(1);
            if (clr_ff == LAST_BKT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in    = req_tdata[KEY_W-1:0];
               func_in   = req_tuser;
               found_in  = 1'b0;
               status_in = 1'b0;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            quot_in  = prod[QS +: BW];
            state_in = ST_LEN_RD;
         end
         ST_LEN_RD: begin
            bucket_in = bucket_rem;
            state_in  = ST_LEN;
         end
         ST_LEN: begin
            len_in = len_rdata;
            idx_in = '0;
            if (func_ff == FUNC_INSERT) begin
               status_in = !room;
               state_in  = ST_DONE;
            end else if (len_rdata == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_KEY_RD;
            end
         end
         ST_KEY_RD: begin
            state_in = ST_KEY_CMP;
         end
         ST_KEY_CMP: begin
            idx_in = idx_inc;
            if (key_rdata == key_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (idx_inc == len_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_KEY_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      func_ff       <= func_in;
      quot_ff       <= quot_in;
      bucket_ff     <= bucket_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2){1'b0}}, rsp_status_ff, rsp_found_ff};

endmodule

// ===== src/chs_check.sv =====
// ----------------------------------------------------------------------------
// chs_check
// Port-level checks of the chained hash set, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_set_assert.svh"

module chs_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [chs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import chs_pkg::*;

   `CHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   `CHS_ASSERT_NOW(a_rsp_excl, clock, reset, rsp_tvalid,
      !(rsp_tdata[0] && rsp_tdata[1]), "found and status both set")

   `CHS_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid,
      rsp_tdata[RSP_DATA_W-1:2] == '0, "rsp pad bits not zero")

   `CHS_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready,
      !req_tready, "req accepted while an item is in work")

endmodule

bind chained_hash_set chs_check u_chs_check (.*);
